// ===== src/qrr_pkg.sv =====
package qrr_pkg;

    // Field widths of the coefficient request and the root result.
    localparam int COEF_WIDTH = 16;
    localparam int ROOT_WIDTH = 32;
    localparam int DISC_WIDTH = 32;

    // The square root has 31 result bits and takes two radicand bits per cell.
    localparam int SQ_BITS     = 31;
    localparam int RAD_BITS    = 2 * SQ_BITS;
    localparam int SQ_REM_BITS = SQ_BITS + 2;

    // The divider produces one quotient bit per cell.
    localparam int DIV_Q_BITS = 37;
    localparam int DIV_D_BITS = 18;

    // Saturation limit of a root, held wide enough for any quotient.
    localparam int SAT_BITS = 65;
    localparam logic [SAT_BITS-1:0] ROOT_MAXP =
        (SAT_BITS'(1) << (ROOT_WIDTH - 1)) - SAT_BITS'(1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NEG_DISC = 2'd1,
        ST_A_ZERO   = 2'd2,
        ST_SAT      = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_a;
        logic signed [COEF_WIDTH-1:0] coef_b;
        logic signed [COEF_WIDTH-1:0] coef_c;
    } coef_req_t;

    typedef struct packed {
        logic signed [ROOT_WIDTH-1:0] root_plus;
        logic signed [ROOT_WIDTH-1:0] root_minus;
        logic signed [DISC_WIDTH-1:0] discriminant;
        status_t                      status;
    } root_rsp_t;

    // Data handed from one square root cell to the next.
    typedef struct packed {
        logic [RAD_BITS-1:0]    rad;
        logic [SQ_REM_BITS-1:0] rem;
        logic [SQ_BITS-1:0]     root;
    } sq_lane_t;

    // Data handed from one divider cell to the next.
    typedef struct packed {
        logic [DIV_Q_BITS-1:0] num;
        logic [DIV_D_BITS-1:0] den;
        logic [DIV_D_BITS-1:0] rem;
        logic [DIV_Q_BITS-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic [ROOT_WIDTH-1:0] value;
        logic                  sat;
    } root_sat_t;

    // Apply the sign to a quotient magnitude and clamp it to the root range.
    function automatic root_sat_t sat_root(input logic [DIV_Q_BITS-1:0] q, input logic neg);
        root_sat_t             r;
        logic [SAT_BITS-1:0]   qx;
        logic [SAT_BITS-1:0]   neg_val;
        qx = SAT_BITS'(q);
        r.sat = 1'b0;
        if (!neg)
        begin
            if (qx > ROOT_MAXP)
            begin
                r.sat = 1'b1;
                qx = ROOT_MAXP;
            end
            r.value = qx[ROOT_WIDTH-1:0];
        end
        else
        begin
            if (qx > ROOT_MAXP + SAT_BITS'(1))
            begin
                r.sat = 1'b1;
                qx = ROOT_MAXP + SAT_BITS'(1);
            end
            neg_val = SAT_BITS'(0) - qx;
            r.value = neg_val[ROOT_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/quadratic_real_roots.sv =====
// Channel   | Direction | Handshake              | Payload
// request   | in        | req_valid / req_stall  | req (coef_a, coef_b, coef_c)
// result    | out       | rsp_valid / rsp_stall  | rsp (roots, discriminant, status)
//
// The pipeline has an input register, products, discriminant, 31 square root
// cells, numerator setup, 37 divider cells and the output register.
// One request is taken every cycle while the result side is not stalled.
// A stall on the result side with a result waiting freezes the whole chain.
// Reset clears all valid bits; the data registers are not reset.
module quadratic_real_roots (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  qrr_pkg::coef_req_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output qrr_pkg::root_rsp_t rsp
);
    import qrr_pkg::*;

    typedef struct packed {
        logic [DISC_WIDTH-1:0] disc;
        logic                  a_zero;
        logic                  disc_neg;
        logic                  a_neg;
        logic signed [30:0]    nb;
        logic [16:0]           d_abs;
        logic                  neg_p;
        logic                  neg_m;
    } side_t;

    logic adv;

    logic                         vld0_reg;
    logic signed [COEF_WIDTH-1:0] a0_reg, b0_reg, c0_reg;

    logic               vld1_reg;
    logic signed [31:0] bb1_next, ac1_next;
    logic signed [31:0] bb1_reg, ac1_reg;
    logic signed [COEF_WIDTH-1:0] a1_reg, b1_reg;

    logic               vld2_reg;
    logic signed [33:0] disc_w;
    logic [15:0]        a_mag;
    side_t              side2_next, side2_reg;
    sq_lane_t           sq0_next;

    sq_lane_t sq_lane [0:SQ_BITS];
    logic     vld_sq_reg [0:SQ_BITS-1];
    side_t    side_sq_reg [0:SQ_BITS-1];

    logic               vld3_reg;
    logic signed [32:0] num_p, num_m;
    logic [32:0]        mag_p, mag_m;
    side_t              side3_next, side3_reg;
    div_lane_t          dvp0_next, dvm0_next;

    div_lane_t dv_p [0:DIV_Q_BITS];
    div_lane_t dv_m [0:DIV_Q_BITS];
    logic      vld_dv_reg [0:DIV_Q_BITS-1];
    side_t     side_dv_reg [0:DIV_Q_BITS-1];

    side_t     side_last;
    root_sat_t sat_p, sat_m;
    root_rsp_t rsp_next;
    logic      rsp_valid_reg;
    root_rsp_t rsp_reg;

    // The chain moves unless a finished result is held by the receiver.
    assign adv       = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld0_reg <= req_valid;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld_sq_reg[SQ_BITS-1];
        end
    end

    // Products b*b and a*c.
    assign bb1_next = b0_reg * b0_reg;
    assign ac1_next = a0_reg * c0_reg;

    // Discriminant, its clamped copy and the square root radicand.
    always_comb
    begin
        disc_w = 34'(bb1_reg) - (34'(ac1_reg) <<< 2);
        a_mag  = a1_reg[COEF_WIDTH-1] ? 16'(-a1_reg) : 16'(a1_reg);
        side2_next.a_zero   = (a1_reg == '0);
        side2_next.disc_neg = disc_w[33];
        side2_next.a_neg    = a1_reg[COEF_WIDTH-1];
        side2_next.nb       = -(31'(b1_reg)) <<< 14;
        side2_next.d_abs    = {a_mag, 1'b0};
        side2_next.neg_p    = 1'b0;
        side2_next.neg_m    = 1'b0;
        if (disc_w > 34'sh0_7FFF_FFFF)
        begin
            side2_next.disc = 32'h7FFF_FFFF;
        end
        else if (disc_w < 34'sh3_8000_0000)
        begin
            side2_next.disc = 32'h8000_0000;
        end
        else
        begin
            side2_next.disc = disc_w[31:0];
        end
        sq0_next.rem  = '0;
        sq0_next.root = '0;
        if (!side2_next.a_zero && !disc_w[33])
        begin
            sq0_next.rad = {disc_w, 28'd0};
        end
        else
        begin
            sq0_next.rad = '0;
        end
    end

    // Front stage data registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a0_reg    <= req.coef_a;
            b0_reg    <= req.coef_b;
            c0_reg    <= req.coef_c;
            bb1_reg   <= bb1_next;
            ac1_reg   <= ac1_next;
            a1_reg    <= a0_reg;
            b1_reg    <= b0_reg;
            side2_reg <= side2_next;
            sq_lane[0] <= sq0_next;
        end
    end

    // Square root chain with its side data alongside.
    genvar k;
    generate
        for (k = 0; k < SQ_BITS; k++)
        begin : g_sq
            qrr_sqrt_cell u_cell (
                .clk      (clk),
                .en       (adv),
                .lane_in  (sq_lane[k]),
                .lane_out (sq_lane[k+1])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_sq_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    if (k == 0)
                    begin
                        vld_sq_reg[k] <= vld2_reg;
                    end
                    else
                    begin
                        vld_sq_reg[k] <= vld_sq_reg[(k == 0) ? 0 : k-1];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (k == 0)
                    begin
                        side_sq_reg[k] <= side2_reg;
                    end
                    else
                    begin
                        side_sq_reg[k] <= side_sq_reg[(k == 0) ? 0 : k-1];
                    end
                end
            end
        end
    endgenerate

    // Numerators -b*2^14 +/- sqrt, scaled and offset for rounding.
    always_comb
    begin
        side3_next = side_sq_reg[SQ_BITS-1];
        num_p = 33'(side3_next.nb) + $signed({2'b00, sq_lane[SQ_BITS].root});
        num_m = 33'(side3_next.nb) - $signed({2'b00, sq_lane[SQ_BITS].root});
        mag_p = num_p[32] ? 33'(-num_p) : 33'(num_p);
        mag_m = num_m[32] ? 33'(-num_m) : 33'(num_m);
        side3_next.neg_p = num_p[32] ^ side3_next.a_neg;
        side3_next.neg_m = num_m[32] ^ side3_next.a_neg;
        dvp0_next.num = {1'b0, mag_p, 3'b000} + DIV_Q_BITS'(side3_next.d_abs);
        dvm0_next.num = {1'b0, mag_m, 3'b000} + DIV_Q_BITS'(side3_next.d_abs);
        dvp0_next.den = {side3_next.d_abs, 1'b0};
        dvm0_next.den = {side3_next.d_abs, 1'b0};
        dvp0_next.rem = '0;
        dvm0_next.rem = '0;
        dvp0_next.quo = '0;
        dvm0_next.quo = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side3_reg <= side3_next;
            dv_p[0]   <= dvp0_next;
            dv_m[0]   <= dvm0_next;
        end
    end

    // Two divider chains, one per root, sharing the side data.
    generate
        for (k = 0; k < DIV_Q_BITS; k++)
        begin : g_dv
            qrr_div_cell u_cell_p (
                .clk      (clk),
                .en       (adv),
                .lane_in  (dv_p[k]),
                .lane_out (dv_p[k+1])
            );

            qrr_div_cell u_cell_m (
                .clk      (clk),
                .en       (adv),
                .lane_in  (dv_m[k]),
                .lane_out (dv_m[k+1])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_dv_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    if (k == 0)
                    begin
                        vld_dv_reg[k] <= vld3_reg;
                    end
                    else
                    begin
                        vld_dv_reg[k] <= vld_dv_reg[(k == 0) ? 0 : k-1];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (k == 0)
                    begin
                        side_dv_reg[k] <= side3_reg;
                    end
                    else
                    begin
                        side_dv_reg[k] <= side_dv_reg[(k == 0) ? 0 : k-1];
                    end
                end
            end
        end
    endgenerate

    // Signs, saturation and status of the finished result.
    always_comb
    begin
        side_last = side_dv_reg[DIV_Q_BITS-1];
        sat_p = sat_root(dv_p[DIV_Q_BITS].quo, side_last.neg_p);
        sat_m = sat_root(dv_m[DIV_Q_BITS].quo, side_last.neg_m);
        rsp_next.discriminant = side_last.disc;
        rsp_next.root_plus    = '0;
        rsp_next.root_minus   = '0;
        if (side_last.a_zero)
        begin
            rsp_next.status = ST_A_ZERO;
        end
        else if (side_last.disc_neg)
        begin
            rsp_next.status = ST_NEG_DISC;
        end
        else
        begin
            rsp_next.root_plus  = sat_p.value;
            rsp_next.root_minus = sat_m.value;
            rsp_next.status     = (sat_p.sat || sat_m.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= vld_dv_reg[DIV_Q_BITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/qrr_sqrt_cell.sv =====
module qrr_sqrt_cell (
    input  logic              clk,
    input  logic              en,
    input  qrr_pkg::sq_lane_t lane_in,
    output qrr_pkg::sq_lane_t lane_out
);
    import qrr_pkg::*;

    logic [SQ_REM_BITS+1:0] cur;
    logic [SQ_REM_BITS+1:0] trial;
    logic [SQ_REM_BITS+1:0] diff;
    logic                   ge;
    sq_lane_t               lane_next;
    sq_lane_t               lane_reg;

    // One digit of the restoring square root: bring down two radicand bits
    // and try to subtract four times the root plus one.
    always_comb
    begin
        cur   = {lane_in.rem, lane_in.rad[RAD_BITS-1 -: 2]};
        trial = (SQ_REM_BITS + 2)'({lane_in.root, 2'b01});
        diff  = cur - trial;
        ge    = (cur >= trial);
        lane_next.rad  = lane_in.rad << 2;
        lane_next.rem  = ge ? diff[SQ_REM_BITS-1:0] : cur[SQ_REM_BITS-1:0];
        lane_next.root = {lane_in.root[SQ_BITS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

// ===== src/qrr_div_cell.sv =====
module qrr_div_cell (
    input  logic               clk,
    input  logic               en,
    input  qrr_pkg::div_lane_t lane_in,
    output qrr_pkg::div_lane_t lane_out
);
    import qrr_pkg::*;

    logic [DIV_D_BITS:0] cur;
    logic [DIV_D_BITS:0] diff;
    logic                ge;
    div_lane_t           lane_next;
    div_lane_t           lane_reg;

    // One step of restoring division: shift in the next numerator bit and
    // subtract the divisor when it fits.
    always_comb
    begin
        cur  = {lane_in.rem, lane_in.num[DIV_Q_BITS-1]};
        diff = cur - {1'b0, lane_in.den};
        ge   = (cur >= {1'b0, lane_in.den});
        lane_next.num = lane_in.num << 1;
        lane_next.den = lane_in.den;
        lane_next.rem = ge ? diff[DIV_D_BITS-1:0] : cur[DIV_D_BITS-1:0];
        lane_next.quo = {lane_in.quo[DIV_Q_BITS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule
